// ===== hw/rtl/mbp_pkg.sv =====
// Shared constants and types for the MSB-first bit packer.
package mbp_pkg;

    localparam int MAX_CODE_BITS = 32;
    localparam int VALUE_W       = 32;
    localparam int LEN_W         = 6;
    localparam int PEND_W        = 7;
    localparam int HAVE_W        = 3;
    localparam int ACC_W         = MAX_CODE_BITS + PEND_W;
    localparam int TOT_W         = $clog2(ACC_W + 1);
    localparam int MAX_BYTES     = (PEND_W + MAX_CODE_BITS) / 8;
    localparam int WORD_W        = MAX_BYTES * 8;
    localparam int CNT_W         = $clog2(MAX_BYTES + 1);
    localparam int IDX_W         = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int IN_TDATA_W    = 40;

    // queue between front and back; depth must stay a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic {
        OP_PACK  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // one run of completed bytes, right aligned; highest live byte goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          nbytes;
    } job_t;

endpackage

// ===== hw/rtl/mbp_front.sv =====
// Front end: accepts items, merges codes with pending bits, emits byte runs.
module mbp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [mbp_pkg::VALUE_W-1:0] s_code_value,
    input  logic [mbp_pkg::LEN_W-1:0]   s_bit_len,
    output logic                        push,
    output mbp_pkg::job_t               push_job,
    input  logic                        q_ready
);

    logic [mbp_pkg::PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [mbp_pkg::HAVE_W-1:0] pend_count_reg, pend_count_next;

    logic                        accept;
    mbp_pkg::op_t                op;
    logic [mbp_pkg::LEN_W-1:0]   len_sat;
    logic [mbp_pkg::ACC_W-1:0]   val_mask;
    logic [mbp_pkg::ACC_W-1:0]   acc;
    logic [mbp_pkg::TOT_W-1:0]   total;
    logic [mbp_pkg::CNT_W-1:0]   pack_bytes;
    logic [2:0]                  rem;
    logic [7:0]                  flush_byte;

    assign accept  = s_valid && q_ready;
    assign s_ready = q_ready;
    assign op      = mbp_pkg::op_t'(s_opcode);

    always_comb begin
        len_sat = (s_bit_len > mbp_pkg::LEN_W'(mbp_pkg::MAX_CODE_BITS))
                ? mbp_pkg::LEN_W'(mbp_pkg::MAX_CODE_BITS) : s_bit_len;
        val_mask   = ~({mbp_pkg::ACC_W{1'b1}} << len_sat);
        acc        = (mbp_pkg::ACC_W'(pend_bits_reg) << len_sat)
                   | (mbp_pkg::ACC_W'(s_code_value) & val_mask);
        total      = mbp_pkg::TOT_W'(pend_count_reg) + mbp_pkg::TOT_W'(len_sat);
        pack_bytes = mbp_pkg::CNT_W'(total >> 3);
        rem        = total[2:0];
        // pending bits to the top, ones below
        flush_byte = (8'(pend_bits_reg) << (4'd8 - 4'(pend_count_reg)))
                   | (8'hFF >> pend_count_reg);
    end

    always_comb begin
        push            = 1'b0;
        push_job        = '0;
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        case (op)
            mbp_pkg::OP_PACK: begin
                push_job.bytes  = mbp_pkg::WORD_W'(acc >> rem);
                push_job.nbytes = pack_bytes;
                if (accept) begin
                    push            = (pack_bytes != '0);
                    pend_bits_next  = mbp_pkg::PEND_W'(acc)
                                    & ~({mbp_pkg::PEND_W{1'b1}} << rem);
                    pend_count_next = rem;
                end
            end
            mbp_pkg::OP_FLUSH: begin
                push_job.bytes  = mbp_pkg::WORD_W'(flush_byte);
                push_job.nbytes = mbp_pkg::CNT_W'(1);
                if (accept && (pend_count_reg != '0)) begin
                    push            = 1'b1;
                    pend_bits_next  = '0;
                    pend_count_next = '0;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end else begin
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
        end
    end

endmodule

// ===== hw/rtl/mbp_queue.sv =====
// Short job queue between the front end and the byte drain.
module mbp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mbp_pkg::job_t push_job,
    output logic          q_ready,
    input  logic          pop,
    output logic          q_valid,
    output mbp_pkg::job_t q_job
);

    mbp_pkg::job_t                q_mem_reg [mbp_pkg::QDEPTH];
    logic [mbp_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mbp_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mbp_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign q_ready = (count_reg != mbp_pkg::QCNT_W'(mbp_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/mbp_back.sv =====
// Back end: drains byte runs one byte a cycle into the output register while m_ready allows.
module mbp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  mbp_pkg::job_t q_job,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_byte,
    output logic          m_last
);

    logic [mbp_pkg::MAX_BYTES-1:0][7:0] word_reg, word_next;
    logic [mbp_pkg::CNT_W-1:0]          left_reg, left_next;
    logic                               m_valid_reg, m_valid_next;
    logic [7:0]                         m_byte_reg, m_byte_next;
    logic                               m_last_reg, m_last_next;

    logic                         advance;
    logic [mbp_pkg::CNT_W-1:0]    left_dec;

    assign left_dec = left_reg - 1'b1;
    assign advance  = (left_reg != '0) && (!m_valid_reg || m_ready);
    // take the next run when idle or on the final byte of the current one
    assign pop      = q_valid && ((left_reg == '0)
                    || (advance && (left_reg == mbp_pkg::CNT_W'(1))));

    always_comb begin
        word_next    = word_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_byte_next  = word_reg[left_dec[mbp_pkg::IDX_W-1:0]];
            m_last_next  = (left_reg == mbp_pkg::CNT_W'(1));
            left_next    = left_dec;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            word_next = q_job.bytes;
            left_next = q_job.nbytes;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        if (!aresetn) begin
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_byte  = m_byte_reg;
    assign m_last  = m_last_reg;

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= mbp_pkg::CNT_W'(mbp_pkg::MAX_BYTES))
        else $error("byte count beyond run size");

    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("byte issued but output not valid");

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (left_reg == mbp_pkg::CNT_W'(1))) |=> m_last_reg)
        else $error("final byte of run without last");

    a_mid_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (left_reg > mbp_pkg::CNT_W'(1))) |=> !m_last_reg)
        else $error("last raised before end of run");

endmodule

// ===== hw/rtl/msb_first_bit_packer_unit.sv =====
// Top level of the MSB-first variable-length bit packer.
// Path: a completed byte passes through the job queue, the back end's run
// register and the output register to m_*. Throughput: one item per cycle in
// while the queue has room; one byte per cycle out while m_tready is high. A
// run is at most 4 bytes; the 2-entry job queue takes runs while one drains.
// Reset: synchronous, active low; clears pending bits, queue and output valid.
module msb_first_bit_packer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] code_value, [37:32] bit_len, [39:38] zero
    input  logic [mbp_pkg::IN_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_byte
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast
);

    logic          push;
    mbp_pkg::job_t push_job;
    logic          q_ready;
    logic          pop;
    logic          q_valid;
    mbp_pkg::job_t q_job;

    mbp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_opcode     (s_tuser),
        .s_code_value (s_tdata[mbp_pkg::VALUE_W-1:0]),
        .s_bit_len    (s_tdata[mbp_pkg::VALUE_W +: mbp_pkg::LEN_W]),
        .push         (push),
        .push_job     (push_job),
        .q_ready      (q_ready)
    );

    mbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    mbp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_byte  (m_tdata),
        .m_last  (m_tlast)
    );

endmodule

// ===== tb/msb_first_bit_packer_unit_tb.sv =====
// Self-checking testbench for the MSB-first variable-length bit packer.
module msb_first_bit_packer_unit_tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_SHOWN   = 10;

    // Tracks the pending bits the packer should hold and the bytes it owes.
    class byte_stream_board;
        logic [6:0]  held_bits;
        int unsigned held_count;
        logic [7:0]  owed_byte[$];
        logic        owed_last[$];
        int unsigned errors;
        int unsigned codes_taken;
        int unsigned flushes_taken;
        int unsigned bytes_checked;

        function new();
            held_bits     = '0;
            held_count    = 0;
            errors        = 0;
            codes_taken   = 0;
            flushes_taken = 0;
            bytes_checked = 0;
        endfunction

        function void note_item(mbp_pkg::op_t op, logic [31:0] val,
                                logic [5:0] len);
            logic [63:0] acc;
            logic [63:0] shifted;
            logic [7:0]  pad;
            int unsigned n;
            int unsigned total;
            int unsigned before_count;
            acc = {57'd0, held_bits};
            if (op == mbp_pkg::OP_FLUSH) begin
                flushes_taken++;
                if (held_count != 0) begin
                    shifted = acc << (8 - held_count);
                    pad     = 8'hFF >> held_count;
                    owed_byte.push_back(shifted[7:0] | pad);
                    owed_last.push_back(1'b1);
                    held_bits  = '0;
                    held_count = 0;
                end
                return;
            end
            codes_taken++;
            n = (len > mbp_pkg::MAX_CODE_BITS) ? mbp_pkg::MAX_CODE_BITS : len;
            if (n == 0)
                return;
            acc = (acc << n) | ({32'd0, val} & ((64'd1 << n) - 64'd1));
            total = held_count + n;
            before_count = owed_byte.size();
            while (total >= 8) begin
                total   = total - 8;
                shifted = acc >> total;
                owed_byte.push_back(shifted[7:0]);
                owed_last.push_back(1'b0);
            end
            if (owed_byte.size() > before_count)
                owed_last[owed_last.size() - 1] = 1'b1;
            shifted    = acc & ((64'd1 << total) - 64'd1);
            held_bits  = shifted[6:0];
            held_count = total;
        endfunction

        function void check_byte(logic [7:0] got, logic got_last);
            logic [7:0] want_b;
            logic       want_l;
            bytes_checked++;
            if (owed_byte.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected item: byte %02h last %0b", got, got_last);
                return;
            end
            want_b = owed_byte.pop_front();
            want_l = owed_last.pop_front();
            if (got !== want_b || got_last !== want_l) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("mismatch on byte %0d: expected %02h last %0b, got %02h last %0b",
                             bytes_checked, want_b, want_l, got, got_last);
            end
        endfunction

        function int unsigned waiting();
            return owed_byte.size();
        endfunction

        function void close_out();
            if (owed_byte.size() != 0) begin
                errors += owed_byte.size();
                $display("%0d expected bytes never arrived", owed_byte.size());
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mbp_pkg::IN_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;

    byte_stream_board board;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      hold_off_cycles;
    int unsigned      cycle_count = 0;

    msb_first_bit_packer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, board.waiting());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: checks on the handshake, then picks next cycle's ready
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_byte(m_tdata, m_tlast);
            if (hold_off_cycles > 0) begin
                hold_off_cycles = hold_off_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input mbp_pkg::op_t op, input logic [31:0] val,
                             input logic [5:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, len, val};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_item(op, val, len);
    endtask

    // always waits for a clock edge before checking, so the next item starts on a new step
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (board.waiting() != 0);
    endtask

    task automatic send_random_codes(input int unsigned count);
        int unsigned k;
        int unsigned pick;
        logic [5:0]  len;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_item(mbp_pkg::OP_FLUSH, $urandom, 6'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 40)
                    len = 6'($urandom_range(8, 1));
                else if (pick < 70)
                    len = 6'($urandom_range(24, 9));
                else if (pick < 90)
                    len = 6'($urandom_range(32, 25));
                else
                    len = 6'($urandom_range(63, 0));
                send_item(mbp_pkg::OP_PACK, $urandom, len);
            end
        end
    endtask

    initial begin
        int unsigned k;
        board           = new();
        hold_off_cycles = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= mbp_pkg::OP_PACK;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: corner lengths, flush cases, upper value bits ignored
        send_item(mbp_pkg::OP_FLUSH, 32'hFFFF_FFFF, 6'd63);   // nothing pending
        send_item(mbp_pkg::OP_PACK,  32'hFFFF_FFFF, 6'd0);    // zero-length code
        send_item(mbp_pkg::OP_PACK,  32'h0000_0001, 6'd1);
        send_item(mbp_pkg::OP_FLUSH, 32'd0, 6'd0);            // single one bit padded
        send_item(mbp_pkg::OP_PACK,  32'hFFFF_FFFA, 6'd3);
        send_item(mbp_pkg::OP_FLUSH, 32'd0, 6'd0);
        send_item(mbp_pkg::OP_FLUSH, 32'd0, 6'd0);            // flush after flush
        send_item(mbp_pkg::OP_PACK,  32'h0000_00A5, 6'd8);    // exactly one byte
        send_item(mbp_pkg::OP_PACK,  32'hFFFF_FFFF, 6'd32);
        send_item(mbp_pkg::OP_PACK,  32'h0000_0000, 6'd7);
        // seven held plus 32: four bytes
        send_item(mbp_pkg::OP_PACK,  32'h8000_0000, 6'd32);
        send_item(mbp_pkg::OP_FLUSH, 32'd0, 6'd0);
        send_item(mbp_pkg::OP_PACK,  32'h1234_5678, 6'd63);   // saturates to 32
        send_item(mbp_pkg::OP_PACK,  32'hDEAD_BEEF, 6'd33);
        send_item(mbp_pkg::OP_PACK,  32'h0000_0000, 6'd40);
        send_item(mbp_pkg::OP_PACK,  32'hFFFF_FFE0, 6'd5);    // low bits zero, upper set
        send_item(mbp_pkg::OP_PACK,  32'h0000_0000, 6'd3);
        send_item(mbp_pkg::OP_PACK,  32'h0000_007F, 6'd7);
        send_item(mbp_pkg::OP_PACK,  32'h0000_0000, 6'd32);
        send_item(mbp_pkg::OP_PACK,  32'h0000_8000, 6'd16);
        send_item(mbp_pkg::OP_PACK,  32'h5555_5555, 6'd31);
        send_item(mbp_pkg::OP_FLUSH, 32'd0, 6'd0);
        wait_drained();

        // back-pressure: receiver holds off while long codes keep coming
        hold_off_cycles = 300;
        for (k = 0; k < 16; k++)
            send_item(mbp_pkg::OP_PACK, $urandom, 6'd32);
        send_item(mbp_pkg::OP_FLUSH, 32'd0, 6'd0);
        wait_drained();

        send_idle_pct = 38;
        recv_idle_pct = 86;
        send_random_codes(55);
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 38;
        send_random_codes(55);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_codes(60);
        send_item(mbp_pkg::OP_FLUSH, 32'd0, 6'd0);
        wait_drained();

        // allow for any stray late bytes
        repeat (10) @(posedge aclk);
        board.close_out();

        $display("covered %0d code items and %0d flushes, %0d bytes checked",
                 board.codes_taken, board.flushes_taken, board.bytes_checked);
        $display("including a long output stall and three idle mixes; %0d errors",
                 board.errors);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
